[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/kufe_pkg.sv]
package kufe_pkg;

    localparam int VTX_W        = 8;
    localparam int MAX_VERTICES = 1 << VTX_W;
    localparam int CNT_W        = VTX_W + 1;
    localparam int WEIGHT_W     = 16;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(MAX_VERTICES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK_A,
        ST_WALK_B,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic start_a;
        logic start_b;
        logic walk;
        logic finish_b;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic eligible;
        logic at_root;
        logic out_free;
    } status_t;

endpackage

[design/kufe_edge_if.sv]
interface kufe_edge_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   new_graph;
    logic [kufe_pkg::VTX_W-1:0]             src_vertex;
    logic [kufe_pkg::VTX_W-1:0]             dst_vertex;
    logic signed [kufe_pkg::WEIGHT_W-1:0]   edge_weight;

    modport source (output valid, new_graph, src_vertex, dst_vertex, edge_weight,
                    input ready);
    modport sink (input valid, new_graph, src_vertex, dst_vertex, edge_weight,
                  output ready);
endinterface

[design/kufe_verdict_if.sv]
interface kufe_verdict_if;
    logic                                   valid;
    logic                                   ready;
    logic [kufe_pkg::VTX_W-1:0]             low_vertex;
    logic [kufe_pkg::VTX_W-1:0]             high_vertex;
    logic signed [kufe_pkg::WEIGHT_W-1:0]   weight_out;
    logic                                   accepted;
    logic                                   tree_complete;

    modport source (output valid, low_vertex, high_vertex, weight_out, accepted,
                    tree_complete, input ready);
    modport sink (input valid, low_vertex, high_vertex, weight_out, accepted,
                  tree_complete, output ready);
endinterface

[design/kufe_ram.sv]
module kufe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/kufe_ctrl.sv]
module kufe_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  kufe_pkg::status_t status,
    output kufe_pkg::cmd_t    cmd
);

    kufe_pkg::state_t state_reg;
    kufe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kufe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kufe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kufe_pkg::ST_CHECK;
                end
            end
            kufe_pkg::ST_CHECK:
            begin
                state_next = status.eligible ? kufe_pkg::ST_WALK_A : kufe_pkg::ST_RESULT;
            end
            kufe_pkg::ST_WALK_A:
            begin
                if (status.at_root)
                begin
                    state_next = kufe_pkg::ST_WALK_B;
                end
            end
            kufe_pkg::ST_WALK_B:
            begin
                if (status.at_root)
                begin
                    state_next = kufe_pkg::ST_RESULT;
                end
            end
            kufe_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = kufe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kufe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            kufe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            kufe_pkg::ST_CHECK:
            begin
                cmd.start_a = status.eligible;
            end
            kufe_pkg::ST_WALK_A:
            begin
                cmd.start_b = status.at_root;
                cmd.walk    = !status.at_root;
            end
            kufe_pkg::ST_WALK_B:
            begin
                cmd.finish_b = status.at_root;
                cmd.walk     = !status.at_root;
            end
            kufe_pkg::ST_RESULT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[design/kufe_datapath.sv]
`include "assert_macros.svh"

module kufe_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kufe_pkg::CNT_W-1:0]      cfg_wdata,
    input  kufe_pkg::cmd_t                  cmd,
    output kufe_pkg::status_t               status,
    kufe_edge_if.sink                       edges,
    kufe_verdict_if.source                  verdicts
);

    logic [kufe_pkg::CNT_W-1:0]         vcount_reg;
    logic [kufe_pkg::CNT_W-1:0]         count_reg;
    logic [kufe_pkg::VTX_W-1:0]         a_reg;
    logic [kufe_pkg::VTX_W-1:0]         b_reg;
    logic signed [kufe_pkg::WEIGHT_W-1:0] w_reg;
    logic [kufe_pkg::VTX_W-1:0]         cur_reg;
    logic [kufe_pkg::VTX_W-1:0]         root_a_reg;
    logic                               ok_reg;
    logic [kufe_pkg::MAX_VERTICES-1:0]  linked_reg;

    logic                               out_valid_reg;
    logic [kufe_pkg::VTX_W-1:0]         out_low_reg;
    logic [kufe_pkg::VTX_W-1:0]         out_high_reg;
    logic signed [kufe_pkg::WEIGHT_W-1:0] out_weight_reg;
    logic                               out_ok_reg;
    logic                               out_done_reg;

    logic [kufe_pkg::CNT_W-1:0]         n_used;
    logic [kufe_pkg::CNT_W-1:0]         need;
    logic [kufe_pkg::VTX_W-1:0]         rdata;
    logic [kufe_pkg::VTX_W-1:0]         parent;
    logic [kufe_pkg::VTX_W-1:0]         raddr;
    logic                               link;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_used = kufe_pkg::CNT_W'(1);
        end
        else if (vcount_reg > kufe_pkg::CNT_W'(kufe_pkg::MAX_VERTICES))
        begin
            n_used = kufe_pkg::CNT_W'(kufe_pkg::MAX_VERTICES);
        end
        else
        begin
            n_used = vcount_reg;
        end
    end

    assign need = n_used - kufe_pkg::CNT_W'(1);

    // An entry never linked since the last clear is its own parent.
    assign parent = linked_reg[cur_reg] ? rdata : cur_reg;
    assign link   = cmd.finish_b && (cur_reg != root_a_reg);

    always_comb
    begin
        if (cmd.start_a)
        begin
            raddr = a_reg;
        end
        else if (cmd.start_b)
        begin
            raddr = b_reg;
        end
        else
        begin
            raddr = parent;
        end
    end

    kufe_ram #(
        .WIDTH (kufe_pkg::VTX_W),
        .DEPTH (kufe_pkg::MAX_VERTICES)
    ) u_parent_ram (
        .clk   (clk),
        .we    (link),
        .waddr (root_a_reg),
        .wdata (cur_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.eligible = (count_reg < need)
                             && ({1'b0, a_reg} < n_used)
                             && ({1'b0, b_reg} < n_used);
    assign status.at_root  = (parent == cur_reg);
    assign status.out_free = !out_valid_reg || verdicts.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= kufe_pkg::VCOUNT_RESET;
            count_reg     <= '0;
            ok_reg        <= 1'b0;
            linked_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                ok_reg <= 1'b0;
                if (edges.new_graph)
                begin
                    count_reg  <= '0;
                    linked_reg <= '0;
                end
            end
            if (link)
            begin
                count_reg              <= count_reg + kufe_pkg::CNT_W'(1);
                ok_reg                 <= 1'b1;
                linked_reg[root_a_reg] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdicts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= edges.src_vertex;
            b_reg <= edges.dst_vertex;
            w_reg <= edges.edge_weight;
        end
        if (cmd.start_a)
        begin
            cur_reg <= a_reg;
        end
        else if (cmd.start_b)
        begin
            root_a_reg <= cur_reg;
            cur_reg    <= b_reg;
        end
        else if (cmd.walk)
        begin
            cur_reg <= parent;
        end
        if (cmd.emit)
        begin
            out_low_reg    <= (a_reg < b_reg) ? a_reg : b_reg;
            out_high_reg   <= (a_reg < b_reg) ? b_reg : a_reg;
            out_weight_reg <= w_reg;
            out_ok_reg     <= ok_reg;
            out_done_reg   <= (count_reg >= need);
        end
    end

    assign verdicts.valid         = out_valid_reg;
    assign verdicts.low_vertex    = out_low_reg;
    assign verdicts.high_vertex   = out_high_reg;
    assign verdicts.weight_out    = out_weight_reg;
    assign verdicts.accepted      = out_ok_reg;
    assign verdicts.tree_complete = out_done_reg;

    `ASSERT_IMP(a_ok_has_count, clk, rst_n, ok_reg, count_reg != '0)
    `ASSERT_NEXT(a_walk_moves, clk, rst_n, cmd.walk, cur_reg != $past(cur_reg))
    `ASSERT_NEXT(a_link_counts, clk, rst_n, link,
                 count_reg == $past(count_reg) + kufe_pkg::CNT_W'(1))
    `ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_reg)

endmodule

[design/kruskal_union_find_edge_filter_core.sv]
// Each input word is one graph edge, sorted by ascending weight, and yields exactly one
// result word saying whether the edge joins two components of the union-find forest.
// After acceptance the block checks the edge in its CHECK state, then walks parent links
// from the source vertex and from the destination vertex, one link per cycle through the
// single read port of the parent table, and registers the result once the output register
// is free; an edge that fails the check is rejected without a walk. The depth of a vertex
// can reach vertex_count minus one since the forest has no rank or path compression. A new
// word is accepted in the cycle after the previous result is registered, even while that
// result still waits. A set new_graph flag clears the forest at once, with no clearing
// pass, and vertex_count may be written only while the block is idle.
module kruskal_union_find_edge_filter_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [kufe_pkg::CNT_W-1:0] cfg_wdata,
    kufe_edge_if.sink                  edges,
    kufe_verdict_if.source             verdicts
);

    kufe_pkg::cmd_t    cmd;
    kufe_pkg::status_t status;
    logic              in_ready;

    kufe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edges.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kufe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .edges     (edges),
        .verdicts  (verdicts)
    );

    assign edges.ready = in_ready;

endmodule
